[src/apr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package apr_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int TABLE_STAGES = 26;
    localparam logic [12:0] LONGEST_DELAY = 13'd7573;
    localparam logic signed [31:0] Q_ONE     = 32'sd134217728;
    localparam logic signed [31:0] Q_PI      = 32'sd421657428;
    localparam logic signed [31:0] Q_HALF_PI = 32'sd210828714;
    localparam logic signed [33:0] Q_TWO_PI  = 34'sd843314857;
    localparam logic signed [31:0] CORDIC_K  = 32'sd81504109;

    // Configuration register indexes.
    localparam logic [2:0] REG_DEPTH    = 3'd0;
    localparam logic [2:0] REG_DAMP     = 3'd1;
    localparam logic [2:0] REG_FEEDBACK = 3'd2;
    localparam logic [2:0] REG_GAIN     = 3'd3;
    localparam logic [2:0] REG_WET      = 3'd4;

    // CORDIC modes.
    typedef enum logic [1:0] {
        MODE_ROTATE = 2'b01,
        MODE_VECTOR = 2'b10
    } cordic_mode_t;

    typedef struct packed {
        logic start;
        logic mode_vec;
    } cordic_ctl_t;

    // Arctangent of 2^-i in Q4.27.
    function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
        logic signed [31:0] r;
        begin
            case (i)
                5'd0: r = 32'sd105414357;
                5'd1: r = 32'sd62229729;
                5'd2: r = 32'sd32880480;
                5'd3: r = 32'sd16690645;
                5'd4: r = 32'sd8377711;
                5'd5: r = 32'sd4192939;
                5'd6: r = 32'sd2096981;
                5'd7: r = 32'sd1048555;
                5'd8: r = 32'sd524285;
                5'd9: r = 32'sd262144;
                default: r = (i < 5'd24) ? (32'sd1 << (5'd27 - i)) : 32'sd0;
            endcase
            return r;
        end
    endfunction

    // Nominal delay length of each stage.
    function automatic logic [12:0] len_entry(input logic [4:0] k);
        logic [12:0] r;
        begin
            case (k)
                5'd0: r = 13'd7573;  5'd1: r = 13'd7307;  5'd2: r = 13'd7177;
                5'd3: r = 13'd6907;  5'd4: r = 13'd6779;  5'd5: r = 13'd6521;
                5'd6: r = 13'd5981;  5'd7: r = 13'd5563;  5'd8: r = 13'd5297;
                5'd9: r = 13'd4903;  5'd10: r = 13'd4759; 5'd11: r = 13'd4489;
                5'd12: r = 13'd4391; 5'd13: r = 13'd4229; 5'd14: r = 13'd4153;
                5'd15: r = 13'd3989; 5'd16: r = 13'd3659; 5'd17: r = 13'd3407;
                5'd18: r = 13'd3251; 5'd19: r = 13'd2999; 5'd20: r = 13'd2917;
                5'd21: r = 13'd2749; 5'd22: r = 13'd2503; 5'd23: r = 13'd2423;
                5'd24: r = 13'd2146; 5'd25: r = 13'd2088;
                default: r = 13'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        begin
            if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -36'sd2147483648) return 32'sh80000000;
            return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

[src/allpass_chain_reverb.sv]
`timescale 1ns / 1ps
`default_nettype none
// Series allpass reverb for one audio channel. Each sample word runs
// through a sine shaper, the last depth_stages allpass stages, an arcsine
// shaper and a wet/dry mix, one word at a time. A word passes through sine
// argument reduction, a CORDIC rotation pass, the delay-memory read, write
// and damping steps of each stage used, feedback, gain, a square root, a
// CORDIC vectoring pass and the mix. Before the next sample is taken, the
// delay base address is walked to the first stage used. One CORDIC serves
// both shaper passes. A finished word waits in the output register while
// the next sample is processed; the block stalls before its next mix only
// if that word has still not been taken. After reset all 131072 words of
// the delay memory are cleared, one word per cycle, before the first
// sample is taken; configuration writes are accepted during that time.
module allpass_chain_reverb #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // s_axis_tdata: sample_in
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // m_axis_tdata: sample_out
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [16:0]            cfg_data
);
    import apr_pkg::*;

    localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int STORE_AW = 17;

    typedef enum logic [12:0] {
        ST_CLEAR   = 13'b0000000000001,
        ST_IDLE    = 13'b0000000000010,
        ST_SIN     = 13'b0000000000100,
        ST_SINW    = 13'b0000000001000,
        ST_RD      = 13'b0000000010000,
        ST_RDW     = 13'b0000000100000,
        ST_WR      = 13'b0000001000000,
        ST_DAMP    = 13'b0000010000000,
        ST_FB      = 13'b0000100000000,
        ST_GAIN    = 13'b0001000000000,
        ST_SQRT    = 13'b0010000000000,
        ST_ASIN    = 13'b0100000000000,
        ST_MIX     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [4:0]  depth_reg, damp_reg;
    logic [2:0]  fb_level_reg;
    logic [16:0] gain_reg, wet_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= 5'd13;
            damp_reg     <= 5'd6;
            fb_level_reg <= 3'd3;
            gain_reg     <= 17'd65536;
            wet_reg      <= 17'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEPTH:    depth_reg    <= cfg_data[4:0];
                REG_DAMP:     damp_reg     <= cfg_data[4:0];
                REG_FEEDBACK: fb_level_reg <= cfg_data[2:0];
                REG_GAIN:     gain_reg     <= cfg_data;
                REG_WET:      wet_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-stage state.
    logic [12:0]        ptr_reg  [TABLE_STAGES];
    logic signed [31:0] damp_mem [TABLE_STAGES];
    logic signed [31:0] fb_reg, fb_next;

    logic [STORE_AW-1:0] clr_reg, clr_next;
    logic [4:0]          k_reg, k_next;
    logic [STORE_AW-1:0] base_reg, base_next;
    logic signed [35:0]  s_reg, s_next;
    logic signed [35:0]  dry_reg, dry_next;
    logic signed [31:0]  tap_reg, tap_next;
    logic [TDW-1:0]      out_reg, out_next;
    logic                ovalid_reg, ovalid_next;

    // Stage geometry derived for the current stage.
    logic [12:0] len_k, ptr_k, nxt_k;
    logic [4:0]  depth_eff;
    logic [4:0]  k_first;
    always_comb
    begin
        len_k = (k_reg == 5'd0 || len_entry(k_reg) > LONGEST_DELAY) ? LONGEST_DELAY
                                                                     : len_entry(k_reg);
        ptr_k = (ptr_reg[k_reg] > len_k) ? len_k : ptr_reg[k_reg];
        nxt_k = (ptr_k == 13'd0) ? len_k : ptr_k - 13'd1;
        depth_eff = (depth_reg > 5'(TABLE_STAGES)) ? 5'(TABLE_STAGES) : depth_reg;
        k_first = 5'(TABLE_STAGES) - depth_eff;
    end

    // Base of the first stage run: sum of lengths of the skipped stages, plus one each.
    logic [STORE_AW-1:0] base_add;
    assign base_add = STORE_AW'(len_k) + 17'd1;

    // Delay memory.
    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]         ram_wdata, ram_rdata;

    apr_ram #(.WIDTH(32), .DEPTH(1 << STORE_AW)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared CORDIC and square root.
    cordic_ctl_t        cctl;
    logic signed [35:0] cx, cy, cz, cy_out, cz_out;
    logic               cdone;
    apr_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .ctl(cctl), .x_in(cx), .y_in(cy), .z_in(cz),
        .done(cdone), .y_out(cy_out), .z_out(cz_out)
    );

    logic        sq_start, sq_done;
    logic [55:0] sq_rad;
    logic [27:0] sq_root;
    apr_isqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_rad),
        .done(sq_done), .root(sq_root)
    );

    // Datapath helpers.
    logic signed [35:0] v_in, arg, arg2, tap_ext, wr_val, s_half;
    logic signed [55:0] vsq;
    logic signed [53:0] gprod;
    logic signed [52:0] mix;
    logic [16:0]        w_eff;
    logic signed [35:0] gsc, mixed;
    logic               damped;
    logic [SAMPLE_BITS-1:0] in_smp;

    assign in_smp  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign damped  = 32'(damp_reg) > (32'(TABLE_STAGES) - 32'(k_reg));
    assign tap_ext = 36'(tap_reg);
    assign wr_val  = 36'(sat32(s_reg - (tap_ext >>> 1)));
    assign s_half  = 36'(sat32((wr_val >>> 1) + tap_ext));
    assign w_eff   = (wet_reg > 17'd65536) ? 17'd65536 : wet_reg;

    always_comb
    begin
        if (SAMPLE_BITS <= 28)
            v_in = 36'(signed'(in_smp)) <<< (28 - SAMPLE_BITS);
        else
            v_in = 36'(signed'(in_smp)) >>> (SAMPLE_BITS - 28);
        // Fold the reduced sine argument into [-pi/2, pi/2].
        arg  = s_reg;
        arg2 = arg;
        if (arg > 36'(Q_HALF_PI)) arg2 = 36'(Q_PI) - arg;
        if (arg < -36'(Q_HALF_PI)) arg2 = -36'(Q_PI) - arg;
        gprod = 54'(s_reg) * 54'(signed'({1'b0, gain_reg}));
        gsc   = 36'(gprod >>> 16);
        if (gsc > 36'(Q_ONE)) gsc = 36'(Q_ONE);
        if (gsc < -36'(Q_ONE)) gsc = -36'(Q_ONE);
        // The clamped value fits in 29 bits, so the square stays narrow.
        vsq   = 56'(signed'(s_reg[28:0])) * 56'(signed'(s_reg[28:0]));
        mix   = 53'(s_reg) * 53'(signed'({1'b0, w_eff}))
              + 53'(dry_reg) * 53'(signed'(18'd65536 - {1'b0, w_eff}));
        mixed = 36'(mix >>> 16);
    end

    // Output saturation.
    logic signed [35:0] o_scaled;
    logic signed [35:0] lim;
    logic [SAMPLE_BITS-1:0] o_sat;
    always_comb
    begin
        if (SAMPLE_BITS <= 28)
            o_scaled = mixed >>> (28 - SAMPLE_BITS);
        else
            o_scaled = mixed <<< (SAMPLE_BITS - 28);
        lim = 36'sd1 <<< (SAMPLE_BITS - 1);
        if (o_scaled > lim - 36'sd1) o_sat = SAMPLE_BITS'(lim - 36'sd1);
        else if (o_scaled < -lim) o_sat = SAMPLE_BITS'(-lim);
        else o_sat = SAMPLE_BITS'(o_scaled);
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        k_next      = k_reg;
        base_next   = base_reg;
        s_next      = s_reg;
        dry_next    = dry_reg;
        tap_next    = tap_reg;
        fb_next     = fb_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        ram_we      = 1'b0;
        ram_waddr   = base_reg + STORE_AW'(ptr_k);
        ram_wdata   = wr_val[31:0];
        ram_raddr   = base_reg + STORE_AW'(nxt_k);
        cctl        = '{start: 1'b0, mode_vec: 1'b0};
        cx          = 36'(CORDIC_K);
        cy          = '0;
        cz          = arg2;
        sq_start    = 1'b0;
        sq_rad      = 56'(56'sh40000000000000 - vsq);

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                k_next    = '0;
                base_next = '0;
                if (&clr_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                // Walk the base pointer to the first stage used while waiting.
                if (k_reg < k_first)
                begin
                    base_next = base_reg + base_add;
                    k_next    = k_reg + 5'd1;
                end
                else if (k_reg > k_first)
                begin
                    k_next    = '0;
                    base_next = '0;
                end
                else if (s_axis_tvalid)
                begin
                    dry_next   = v_in;
                    s_next     = 36'(sat32(v_in + 36'(fb_reg)));
                    state_next = ST_SIN;
                end
            end
            ST_SIN:
            begin
                // Reduce the argument into [-pi, pi], one step of 2*pi per cycle.
                if (s_reg > 36'(Q_PI))
                    s_next = s_reg - 36'(Q_TWO_PI);
                else if (s_reg < -36'(Q_PI))
                    s_next = s_reg + 36'(Q_TWO_PI);
                else
                begin
                    cctl       = '{start: 1'b1, mode_vec: 1'b0};
                    state_next = ST_SINW;
                end
            end
            ST_SINW:
            begin
                if (cdone)
                begin
                    s_next     = cy_out;
                    state_next = (k_reg >= 5'(TABLE_STAGES)) ? ST_FB : ST_RD;
                end
            end
            ST_RD:
                state_next = ST_RDW;
            ST_RDW:
            begin
                tap_next   = ram_rdata;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                ram_we     = 1'b1;
                s_next     = s_half;
                state_next = ST_DAMP;
            end
            ST_DAMP:
            begin
                if (damped)
                    s_next = (s_reg + 36'(damp_mem[k_reg])) >>> 1;
                base_next = base_reg + base_add;
                k_next    = k_reg + 5'd1;
                state_next = (k_reg == 5'(TABLE_STAGES - 1)) ? ST_FB : ST_RD;
            end
            ST_FB:
            begin
                case (fb_level_reg)
                    3'd0: fb_next = '0;
                    3'd1: fb_next = 32'(s_reg >>> 4);
                    3'd2: fb_next = 32'(s_reg >>> 3);
                    3'd3: fb_next = 32'(s_reg >>> 2);
                    3'd4: fb_next = 32'(s_reg >>> 1);
                    default: fb_next = 32'(s_reg);
                endcase
                k_next     = '0;
                base_next  = '0;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                s_next     = gsc;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                sq_start   = 1'b1;
                state_next = ST_ASIN;
            end
            ST_ASIN:
            begin
                if (sq_done)
                begin
                    cctl = '{start: 1'b1, mode_vec: 1'b1};
                    cx   = 36'({8'd0, sq_root});
                    cy   = s_reg;
                    cz   = '0;
                end
                if (cdone)
                begin
                    s_next     = cz_out;
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                // Wait here while the previous word is still held.
                if (!ovalid_reg || m_axis_tready)
                begin
                    out_next    = TDW'(o_sat);
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            k_reg      <= '0;
            base_reg   <= '0;
            fb_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            k_reg      <= k_next;
            base_reg   <= base_next;
            fb_reg     <= fb_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Pointer and damping state per stage; the damping memory takes the
    // undamped stage output after its old value has been used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_STAGES; i++)
            begin
                ptr_reg[i]  <= 13'd1;
                damp_mem[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_WR)
                ptr_reg[k_reg] <= nxt_k;
            if (state_reg == ST_DAMP && damped)
                damp_mem[k_reg] <= s_reg[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        dry_reg <= dry_next;
        tap_reg <= tap_next;
        out_reg <= out_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && (k_reg == k_first);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;
endmodule
`default_nettype wire

[src/apr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module apr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/apr_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
module apr_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [55:0] radicand,
    output logic             done,
    output logic [27:0]      root
);
    // Bit-pair restoring square root, one result bit per cycle.
    // The partial result runs wide until the last steps shift it down.
    logic [55:0] rem_reg, rem_next;
    logic [55:0] res_reg, res_next;
    logic [55:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [56:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start)
        begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = 56'd1 << 54;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[55:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 56'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[27:0];
endmodule
`default_nettype wire

[src/apr_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
module apr_cordic (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire apr_pkg::cordic_ctl_t ctl,
    input  wire logic signed [35:0]   x_in,
    input  wire logic signed [35:0]   y_in,
    input  wire logic signed [35:0]   z_in,
    output logic                      done,
    output logic signed [35:0]        y_out,
    output logic signed [35:0]        z_out
);
    import apr_pkg::*;

    // One shared add/shift micro-rotation per cycle, 24 steps.
    logic signed [35:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [4:0]         i_reg, i_next;
    logic               busy_reg, busy_next, vec_reg, vec_next;
    logic               done_reg, done_next;
    logic               dir_pos;
    logic signed [35:0] xs, ys, at;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        vec_next  = vec_reg;
        done_next = 1'b0;
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        at        = 36'(atan_entry(i_reg));
        dir_pos   = vec_reg ? (y_reg >= 0) : (z_reg >= 0);
        if (ctl.start)
        begin
            x_next    = x_in;
            y_next    = y_in;
            z_next    = z_in;
            i_next    = '0;
            busy_next = 1'b1;
            vec_next  = ctl.mode_vec;
        end
        else if (busy_reg)
        begin
            if (vec_reg == dir_pos)
            begin
                // Vectoring with y >= 0, or rotation with z < 0.
                x_next = x_reg + ys;
                y_next = y_reg - xs;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
            end
            z_next = (vec_reg ^ ~dir_pos) ? z_reg + at : z_reg - at;
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        i_reg   <= i_next;
        vec_reg <= vec_next;
    end

    assign done  = done_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule
`default_nettype wire

[src/apr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module apr_checker #(
    parameter int TDW = 24
) (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           s_axis_tvalid,
    input wire logic           s_axis_tready,
    input wire logic           m_axis_tvalid,
    input wire logic           m_axis_tready,
    input wire logic [TDW-1:0] m_axis_tdata
);
    // A held result word keeps its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Handshake outputs are always known out of reset.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_axis_tready, m_axis_tvalid}))
        else $error("handshake output unknown");

    // An accepted sample keeps the block busy in the next cycle.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("block did not start work");
endmodule

bind allpass_chain_reverb apr_checker #(.TDW(((SAMPLE_BITS + 7) / 8) * 8)) u_apr_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
    import apr_pkg::*;

    localparam int N_STAGES    = 26;
    localparam int LONGEST     = 7573;
    localparam int STORE_WORDS = 131072;
    localparam int ROT_STEPS   = 24;
    localparam int SB          = 24;
    localparam int DW          = ((SB + 7) / 8) * 8;
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
    localparam longint ONE_Q     = 64'sd134217728;
    localparam longint PI_Q      = 64'sd421657428;
    localparam longint HALF_PI_Q = 64'sd210828714;
    localparam longint TWO_PI_Q  = 64'sd843314857;
    localparam longint GAIN_K    = 64'sd81504109;

    // Reverb predictor and store of expected output words.
    class reverb_scoreboard;
        int            line_mem [STORE_WORDS];
        int unsigned   wr_ptr [N_STAGES];
        int            damp_hold [N_STAGES];
        int unsigned   line_len [N_STAGES];
        int unsigned   line_base [N_STAGES];
        int            angle_tab [ROT_STEPS];
        int            loop_back;
        int unsigned   depth, damp_cnt, fb_code, out_gain, wet;
        logic [SB-1:0] expected_words [$];
        int            mismatches;
        int            strays;
        int            checked;

        function new();
            int unsigned lens [N_STAGES];
            int unsigned acc;
            lens = '{7573, 7307, 7177, 6907, 6779, 6521, 5981, 5563, 5297, 4903,
                     4759, 4489, 4391, 4229, 4153, 3989, 3659, 3407, 3251, 2999,
                     2917, 2749, 2503, 2423, 2146, 2088};
            angle_tab = '{105414357, 62229729, 32880480, 16690645, 8377711,
                          4192939, 2096981, 1048555, 524285, 262144, 131072,
                          65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                          256, 128, 64, 32, 16};
            acc = 0;
            foreach (line_mem[i]) line_mem[i] = 0;
            for (int k = 0; k < N_STAGES; k++)
            begin
                line_len[k]  = (k == 0 || lens[k] > LONGEST) ? LONGEST : lens[k];
                line_base[k] = acc;
                acc += line_len[k] + 1;
                wr_ptr[k]    = 1;
                damp_hold[k] = 0;
            end
            loop_back = 0;
            depth = 13; damp_cnt = 6; fb_code = 3; out_gain = 65536; wet = 65536;
            mismatches = 0; strays = 0; checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [16:0] val);
            case (idx)
                REG_DEPTH:    depth    = val[4:0];
                REG_DAMP:     damp_cnt = val[4:0];
                REG_FEEDBACK: fb_code  = val[2:0];
                REG_GAIN:     out_gain = val;
                REG_WET:      wet      = val;
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Rotation-mode CORDIC, angle folded into [-pi/2, pi/2].
        function longint sine_of(longint a);
            longint x, y, nx;
            x = GAIN_K; y = 0;
            while (a > PI_Q) a -= TWO_PI_Q;
            while (a < -PI_Q) a += TWO_PI_Q;
            if (a > HALF_PI_Q) a = PI_Q - a;
            if (a < -HALF_PI_Q) a = -PI_Q - a;
            for (int i = 0; i < ROT_STEPS; i++)
            begin
                if (a >= 0)
                begin
                    nx = x - (y >>> i); y = y + (x >>> i); a -= angle_tab[i];
                end
                else
                begin
                    nx = x + (y >>> i); y = y - (x >>> i); a += angle_tab[i];
                end
                x = nx;
            end
            return y;
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b; r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // Vectoring-mode CORDIC starting from (sqrt(1 - v^2), v).
        function longint arcsine_of(longint v);
            longint x, y, z, nx;
            y = v; z = 0;
            x = longint'(int_root(longint'(ONE_Q * ONE_Q - v * v)));
            for (int i = 0; i < ROT_STEPS; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i); y = y - (x >>> i); z += angle_tab[i];
                end
                else
                begin
                    nx = x - (y >>> i); y = y + (x >>> i); z -= angle_tab[i];
                end
                x = nx;
            end
            return z;
        endfunction

        function longint allpass_stage(int k, longint s);
            int unsigned p, nxt;
            longint tap, held;
            p = wr_ptr[k];
            if (p > line_len[k]) p = line_len[k];
            nxt = (p == 0) ? line_len[k] : p - 1;
            tap = line_mem[(line_base[k] + nxt) % STORE_WORDS];
            s = clip32(s - (tap >>> 1));
            line_mem[(line_base[k] + p) % STORE_WORDS] = int'(s);
            s = clip32((s >>> 1) + tap);
            wr_ptr[k] = nxt;
            if (damp_cnt > N_STAGES - k)
            begin
                held = s;
                s = (s + damp_hold[k]) >>> 1;
                damp_hold[k] = int'(held);
            end
            return s;
        endfunction

        // Runs one accepted sample through the model and queues its output.
        function void note_sample(logic [SB-1:0] smp);
            longint v, dry, s, w, lim;
            int unsigned d;
            v = longint'($signed(smp)) * 16;
            dry = v;
            s = sine_of(clip32(v + loop_back));
            d = (depth > N_STAGES) ? N_STAGES : depth;
            for (int k = N_STAGES - d; k < N_STAGES; k++) s = allpass_stage(k, s);
            case (fb_code)
                0: loop_back = 0;
                1: loop_back = int'(s >>> 4);
                2: loop_back = int'(s >>> 3);
                3: loop_back = int'(s >>> 2);
                4: loop_back = int'(s >>> 1);
                default: loop_back = int'(s);
            endcase
            s = (s * longint'(out_gain)) >>> 16;
            if (s > ONE_Q) s = ONE_Q;
            if (s < -ONE_Q) s = -ONE_Q;
            s = arcsine_of(s);
            w = (wet > 65536) ? 65536 : wet;
            s = (s * w + dry * (65536 - w)) >>> 16;
            s = s >>> 4;
            lim = 64'sd1 << (SB - 1);
            if (s > lim - 1) s = lim - 1;
            if (s < -lim) s = -lim;
            expected_words.push_back(s[SB-1:0]);
        endfunction

        function void check_word(logic [SB-1:0] got);
            logic [SB-1:0] want;
            if (expected_words.size() == 0)
            begin
                strays++;
                $display("ERROR: output word %h arrived with none expected", got);
                return;
            end
            want = expected_words.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: sample_out mismatch, expected %h got %h", want, got);
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [DW-1:0] m_axis_tdata;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [16:0]   cfg_data;

    reverb_scoreboard sb;
    int send_idle;
    int recv_stall;
    int sent;
    int settings_used;

    allpass_chain_reverb #(.SAMPLE_BITS(SB)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Send one sample word; valid stays high when the next word follows at once.
    task automatic send_sample(input logic [SB-1:0] smp);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'(smp);
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_sample(smp);
        sent++;
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
    endtask

    // Write all five registers plus the unused indexes, then drop the enable.
    task automatic apply_setting(input logic [16:0] dep, input logic [16:0] dmp,
                                 input logic [16:0] fb, input logic [16:0] gn,
                                 input logic [16:0] wt);
        logic [16:0] vals [5];
        logic [16:0] junk;
        vals = '{dep, dmp, fb, gn, wt};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(3'(i), vals[i]);
        end
        for (logic [3:0] i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
        begin
            junk = 17'($urandom);
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= junk;
            @(posedge clk);
            sb.set_reg(i[2:0], junk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [SB-1:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return SB'($urandom);
        if (pick < 85) return SB'($signed(13'($urandom)));
        if (pick < 92) return {1'b0, {(SB-1){1'b1}}};
        return {1'b1, {(SB-1){1'b0}}};
    endfunction

    // Output side: random stalls, and every accepted word is checked.
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata[SB-1:0]);
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Stimulus.
    initial
    begin
        logic [SB-1:0] directed [$];
        int per_phase;
        sb = new();
        sent = 0;
        settings_used = 0;
        send_idle = 11;
        recv_stall = 53;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_DEPTH;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words with the reset settings: extremes and bit patterns.
        directed = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
                     24'h555555, 24'hAAAAAA, 24'h400000, 24'hC00000, 24'h7FFFFF,
                     24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h000000,
                     24'h0000FF, 24'hFFFF00, 24'h123456};
        foreach (directed[i]) send_sample(directed[i]);
        drain();

        per_phase = 172;
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle = 53;
                recv_stall = 11;
            end
            if (ph == 6)
            begin
                send_idle = 0;
                recv_stall = 0;
            end
            case (ph)
                // Full chain, every stage but the first damped, unity feedback.
                0: apply_setting(26, 26, 5, 65536, 65536);
                // No stages, no feedback, zero gain, fully dry.
                1: apply_setting(0, 0, 0, 0, 0);
                // Codes past the top: depth and damping above the chain,
                // undefined feedback codes, gain near two, wet above one.
                2: apply_setting(31, 31, 7, 131071, 131071);
                3: apply_setting(1, 27, 6, 100000, 32768);
                4: apply_setting(13, 6, 1, 65536, 49152);
                5: apply_setting(20, 3, 2, 70000, 65535);
                default: apply_setting($urandom_range(0, 31), $urandom_range(0, 31),
                                       $urandom_range(0, 7), $urandom_range(0, 131071),
                                       $urandom_range(0, 131071));
            endcase
            for (int i = 0; i < per_phase; i++) send_sample(random_sample());
            drain();
        end

        // Let any stray word show up before the verdict.
        repeat (400) @(posedge clk);
        $display("Checked %0d output words from %0d samples over %0d register settings,",
                 sb.checked, sent, settings_used);
        $display("with stalls on both stream sides and unused register indexes written.");
        if (sb.mismatches == 0 && sb.strays == 0 && sb.expected_words.size() == 0)
            $display("** allpass_chain_reverb: PASSED **");
        else
            $display("** allpass_chain_reverb: FAILED **");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #40_000_000;
        $display("ERROR: timeout with %0d words outstanding", sb.expected_words.size());
        $display("** allpass_chain_reverb: FAILED **");
        $finish;
    end

endmodule

[sim.f]
src/apr_pkg.sv
src/apr_ram.sv
src/apr_isqrt.sv
src/apr_cordic.sv
src/allpass_chain_reverb.sv
src/apr_checker.sv
verif/tb.sv
